// ===== design/lvd_pkg.sv =====
package lvd_pkg;

    localparam int LVD_MAX_DEGREE    = 255;
    localparam int LVD_FRACTION_BITS = 28;

    localparam int WORD_W = 64;
    localparam int X_W    = 32;
    localparam int DEG_W  = 8;

    typedef struct packed {
        logic signed [X_W-1:0]   x_value;
        logic        [DEG_W-1:0] degree;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] poly_value;
        logic signed [WORD_W-1:0] first_derivative;
        logic signed [WORD_W-1:0] second_derivative;
        logic                     saturated;
    } out_t;

    // Multiplier request: frac selects the fixed-point shift, else integer product
    typedef struct packed {
        logic start;
        logic frac;
    } mul_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL_C,
        ST_MUL_CP,
        ST_MUL_PM,
        ST_DIV_P,
        ST_MUL_XD,
        ST_MUL_TK,
        ST_MUL_DM,
        ST_DIV_D,
        ST_MUL_DK,
        ST_MUL_CE,
        ST_MUL_EM,
        ST_DIV_E
    } state_t;

endpackage

// ===== design/lvd_mul.sv =====
module lvd_mul #(
    parameter int FRACTION_BITS = lvd_pkg::LVD_FRACTION_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lvd_pkg::mul_ctl_t         ctl,
    input  logic [lvd_pkg::WORD_W-1:0] a,
    input  logic [lvd_pkg::WORD_W-1:0] b,
    output logic                      done,
    output logic [lvd_pkg::WORD_W-1:0] product,
    output logic                      clip
);

    localparam int W = lvd_pkg::WORD_W;
    localparam int H = W / 2;

    localparam logic [2:0] PP_LAST  = 3'd3;
    localparam logic [2:0] ACC_LAST = 3'd4;
    localparam logic [2:0] NEG_STEP = 3'd5;
    localparam logic [2:0] OUT_STEP = 3'd6;

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    logic           busy_reg, busy_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [W-1:0]   ua_reg, ua_next;
    logic [W-1:0]   ub_reg, ub_next;
    logic           neg_reg, neg_next;
    logic           frac_reg, frac_next;
    logic [W-1:0]   pp_reg, pp_next;
    logic [1:0]     off_reg, off_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   product_reg, product_next;
    logic           clip_reg, clip_next;

    logic [H-1:0]   a_half;
    logic [H-1:0]   b_half;
    logic [W-1:0]   pp_mul;
    logic [2*W-1:0] addend;
    logic [2*W-1:0] shifted;
    logic           ovf;

    always_comb
    begin
        a_half = cnt_reg[1] ? ua_reg[W-1:H] : ua_reg[H-1:0];
        b_half = cnt_reg[0] ? ub_reg[W-1:H] : ub_reg[H-1:0];
        pp_mul = a_half * b_half;

        case (off_reg)
            2'd0:    addend = {{W{1'b0}}, pp_reg};
            2'd1:    addend = {{H{1'b0}}, pp_reg, {H{1'b0}}};
            default: addend = {pp_reg, {W{1'b0}}};
        endcase

        shifted = frac_reg ? (2*W)'($signed(acc_reg) >>> FRACTION_BITS) : acc_reg;
        ovf     = shifted[2*W-1:W] != {W{shifted[W-1]}};

        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        ua_next      = ua_reg;
        ub_next      = ub_reg;
        neg_next     = neg_reg;
        frac_next    = frac_reg;
        pp_next      = pp_reg;
        off_next     = off_reg;
        acc_next     = acc_reg;
        product_next = product_reg;
        clip_next    = clip_reg;

        if (ctl.start)
        begin
            ua_next   = a[W-1] ? (W'(0) - a) : a;
            ub_next   = b[W-1] ? (W'(0) - b) : b;
            neg_next  = a[W-1] ^ b[W-1];
            frac_next = ctl.frac;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg <= PP_LAST)
            begin
                pp_next  = pp_mul;
                off_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != '0 && cnt_reg <= ACC_LAST)
            begin
                acc_next = acc_reg + addend;
            end
            if (cnt_reg == NEG_STEP && neg_reg)
            begin
                acc_next = (2*W)'(0) - acc_reg;
            end
            if (cnt_reg == OUT_STEP)
            begin
                clip_next    = ovf;
                product_next = ovf ? (shifted[2*W-1] ? NEG_MIN : POS_MAX) : shifted[W-1:0];
                done_next    = 1'b1;
                busy_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg      <= ua_next;
        ub_reg      <= ub_next;
        neg_reg     <= neg_next;
        frac_reg    <= frac_next;
        pp_reg      <= pp_next;
        off_reg     <= off_next;
        acc_reg     <= acc_next;
        product_reg <= product_next;
        clip_reg    <= clip_next;
    end

    assign done    = done_reg;
    assign product = product_reg;
    assign clip    = clip_reg;

endmodule

// ===== design/lvd_div.sv =====
module lvd_div #(
    parameter int JW = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lvd_pkg::WORD_W-1:0] dividend,
    input  logic [JW-1:0]              divisor,
    output logic                       done,
    output logic [lvd_pkg::WORD_W-1:0] quotient
);

    localparam int W     = lvd_pkg::WORD_W;
    localparam int STEPS = 8;
    localparam int ITER  = W / STEPS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W-1:0]     q_reg, q_next;
    logic [JW-1:0]    r_reg, r_next;
    logic [JW-1:0]    d_reg, d_next;
    logic             neg_reg, neg_next;

    logic [JW:0]      trial;
    logic [JW-1:0]    r_step;
    logic [W-1:0]     q_step;

    always_comb
    begin
        r_step = r_reg;
        q_step = q_reg;
        trial  = '0;
        // restoring division, STEPS quotient bits per cycle; remainder stays below divisor
        for (int i = 0; i < STEPS; i++)
        begin
            trial  = {r_step, q_step[W-1]};
            q_step = {q_step[W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                trial     = trial - {1'b0, d_reg};
                q_step[0] = 1'b1;
            end
            r_step = trial[JW-1:0];
        end

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            q_next    = dividend[W-1] ? (W'(0) - dividend) : dividend;
            neg_next  = dividend[W-1];
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ITER))
            begin
                // truncate toward zero: restore the sign on the magnitude quotient
                q_next    = neg_reg ? (W'(0) - q_reg) : q_reg;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                q_next = q_step;
                r_next = r_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/legendre_value_and_derivatives_core.sv =====
// Channel   Ports                 Transfer
// input     start, busy, item     rising edge with start high and busy low
// result    done, result          rising edge ending the one cycle done is high
//
// Degree 0 and 1 need no recurrence step; degree n >= 2 runs the recurrence
// for j = 2 .. n. Each recurrence step runs nine products through one shared
// 32x32 multiplier and three divisions by j through one 8-bit-per-cycle divider.
// Reset is asynchronous, active low; it clears the sequencer, strobes and saturation flag only.
// busy stays high from transfer until the cycle done is raised; the receiver
// takes every result as it appears.
module legendre_value_and_derivatives_core #(
    parameter int MAX_DEGREE    = lvd_pkg::LVD_MAX_DEGREE,
    parameter int FRACTION_BITS = lvd_pkg::LVD_FRACTION_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lvd_pkg::in_t  item,
    output logic          busy,
    output logic          done,
    output lvd_pkg::out_t result
);

    localparam int W   = lvd_pkg::WORD_W;
    localparam int XW  = lvd_pkg::X_W;
    localparam int JW  = $clog2(MAX_DEGREE + 1);
    localparam int CW  = (JW > lvd_pkg::DEG_W) ? JW : lvd_pkg::DEG_W;

    localparam logic [W-1:0] ONE     = W'(1) << FRACTION_BITS;
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    lvd_pkg::state_t state_reg, state_next;
    logic            launched_reg, launched_next;
    logic            done_reg, done_next;
    logic            clip_reg, clip_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [JW-1:0]   n_reg, n_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [W-1:0]    c_reg, c_next;
    logic [W-1:0]    t_reg, t_next;
    logic [W-1:0]    p1_reg, p1_next;
    logic [W-1:0]    p2_reg, p2_next;
    logic [W-1:0]    d1_reg, d1_next;
    logic [W-1:0]    d2_reg, d2_next;
    logic [W-1:0]    e1_reg, e1_next;
    logic [W-1:0]    e2_reg, e2_next;
    logic [W-1:0]    pn_reg, pn_next;
    logic [W-1:0]    dn_reg, dn_next;
    lvd_pkg::out_t   result_reg, result_next;

    lvd_pkg::mul_ctl_t mul_ctl;
    logic              mul_op;
    logic [W-1:0]      mul_a;
    logic [W-1:0]      mul_b;
    logic              mul_done;
    logic [W-1:0]      mul_res;
    logic              mul_clip;

    logic              div_op;
    logic              div_start;
    logic              div_done;
    logic [W-1:0]      div_q;

    logic [JW:0]       k_val;
    logic [JW-1:0]     m_val;
    logic [JW+1:0]     k2_val;
    logic [W-1:0]      x_word;
    logic [CW-1:0]     deg_ext;
    logic [CW-1:0]     n_clip;

    logic [W-1:0]      sat_a;
    logic [W-1:0]      sat_b;
    logic              sat_sub;
    logic [W:0]        sat_res;

    // {clip, value}: add or subtract, clipped to the signed word range
    function automatic logic [W:0] sat_add_sub(input logic [W-1:0] a, input logic [W-1:0] b,
                                               input logic sub);
        logic [W:0] s;
        logic [W:0] r;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1])
            r = {1'b1, s[W] ? NEG_MIN : POS_MAX};
        else
            r = {1'b0, s[W-1:0]};
        return r;
    endfunction

    assign k_val   = {j_reg, 1'b0} - (JW+1)'(1);
    assign m_val   = j_reg - JW'(1);
    assign k2_val  = {k_val, 1'b0};
    assign x_word  = {{(W-XW){x_reg[XW-1]}}, x_reg};
    assign deg_ext = CW'(item.degree);
    assign n_clip  = (deg_ext > CW'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : deg_ext;

    always_comb
    begin
        sat_a   = (state_reg == lvd_pkg::ST_MUL_XD) ? mul_res : t_reg;
        sat_b   = (state_reg == lvd_pkg::ST_MUL_XD) ? p1_reg : mul_res;
        sat_sub = !(state_reg == lvd_pkg::ST_MUL_XD || state_reg == lvd_pkg::ST_MUL_CE);
        sat_res = sat_add_sub(sat_a, sat_b, sat_sub);
    end

    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        done_next     = 1'b0;
        clip_next     = clip_reg;
        x_next        = x_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        c_next        = c_reg;
        t_next        = t_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        e1_next       = e1_reg;
        e2_next       = e2_reg;
        pn_next       = pn_reg;
        dn_next       = dn_reg;
        result_next   = result_reg;
        mul_op        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        mul_ctl.frac  = 1'b0;
        div_op        = 1'b0;

        unique case (state_reg)
            lvd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = item.x_value;
                    n_next     = JW'(n_clip);
                    j_next     = JW'(2);
                    clip_next  = 1'b0;
                    p2_next    = ONE;
                    d2_next    = '0;
                    e2_next    = '0;
                    e1_next    = '0;
                    state_next = lvd_pkg::ST_INIT;
                end
            end
            lvd_pkg::ST_INIT:
            begin
                p1_next = (n_reg == '0) ? ONE : x_word;
                d1_next = (n_reg == '0) ? '0 : ONE;
                if (n_reg < JW'(2))
                begin
                    result_next.poly_value        = (n_reg == '0) ? ONE : x_word;
                    result_next.first_derivative  = (n_reg == '0) ? '0 : ONE;
                    result_next.second_derivative = '0;
                    result_next.saturated         = 1'b0;
                    done_next                     = 1'b1;
                    state_next                    = lvd_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lvd_pkg::ST_MUL_C;
                end
            end
            lvd_pkg::ST_MUL_C:
            begin
                mul_op = 1'b1;
                mul_a  = x_word;
                mul_b  = W'(k_val);
                if (mul_done)
                begin
                    c_next     = mul_res;
                    state_next = lvd_pkg::ST_MUL_CP;
                end
            end
            lvd_pkg::ST_MUL_CP:
            begin
                mul_op       = 1'b1;
                mul_a        = c_reg;
                mul_b        = p1_reg;
                mul_ctl.frac = 1'b1;
                if (mul_done)
                begin
                    t_next     = mul_res;
                    state_next = lvd_pkg::ST_MUL_PM;
                end
            end
            lvd_pkg::ST_MUL_PM:
            begin
                mul_op = 1'b1;
                mul_a  = p2_reg;
                mul_b  = W'(m_val);
                if (mul_done)
                begin
                    t_next     = sat_res[W-1:0];
                    clip_next  = clip_reg | sat_res[W];
                    state_next = lvd_pkg::ST_DIV_P;
                end
            end
            lvd_pkg::ST_DIV_P:
            begin
                div_op = 1'b1;
                if (div_done)
                begin
                    pn_next    = div_q;
                    state_next = lvd_pkg::ST_MUL_XD;
                end
            end
            lvd_pkg::ST_MUL_XD:
            begin
                mul_op       = 1'b1;
                mul_a        = x_word;
                mul_b        = d1_reg;
                mul_ctl.frac = 1'b1;
                if (mul_done)
                begin
                    t_next     = sat_res[W-1:0];
                    clip_next  = clip_reg | sat_res[W];
                    state_next = lvd_pkg::ST_MUL_TK;
                end
            end
            lvd_pkg::ST_MUL_TK:
            begin
                mul_op = 1'b1;
                mul_a  = t_reg;
                mul_b  = W'(k_val);
                if (mul_done)
                begin
                    t_next     = mul_res;
                    state_next = lvd_pkg::ST_MUL_DM;
                end
            end
            lvd_pkg::ST_MUL_DM:
            begin
                mul_op = 1'b1;
                mul_a  = d2_reg;
                mul_b  = W'(m_val);
                if (mul_done)
                begin
                    t_next     = sat_res[W-1:0];
                    clip_next  = clip_reg | sat_res[W];
                    state_next = lvd_pkg::ST_DIV_D;
                end
            end
            lvd_pkg::ST_DIV_D:
            begin
                div_op = 1'b1;
                if (div_done)
                begin
                    dn_next    = div_q;
                    state_next = lvd_pkg::ST_MUL_DK;
                end
            end
            lvd_pkg::ST_MUL_DK:
            begin
                mul_op = 1'b1;
                mul_a  = d1_reg;
                mul_b  = W'(k2_val);
                if (mul_done)
                begin
                    t_next     = mul_res;
                    state_next = lvd_pkg::ST_MUL_CE;
                end
            end
            lvd_pkg::ST_MUL_CE:
            begin
                mul_op       = 1'b1;
                mul_a        = c_reg;
                mul_b        = e1_reg;
                mul_ctl.frac = 1'b1;
                if (mul_done)
                begin
                    t_next     = sat_res[W-1:0];
                    clip_next  = clip_reg | sat_res[W];
                    state_next = lvd_pkg::ST_MUL_EM;
                end
            end
            lvd_pkg::ST_MUL_EM:
            begin
                mul_op = 1'b1;
                mul_a  = e2_reg;
                mul_b  = W'(m_val);
                if (mul_done)
                begin
                    t_next     = sat_res[W-1:0];
                    clip_next  = clip_reg | sat_res[W];
                    state_next = lvd_pkg::ST_DIV_E;
                end
            end
            lvd_pkg::ST_DIV_E:
            begin
                div_op = 1'b1;
                if (div_done)
                begin
                    // advance the recurrence window
                    p2_next = p1_reg;
                    p1_next = pn_reg;
                    d2_next = d1_reg;
                    d1_next = dn_reg;
                    e2_next = e1_reg;
                    e1_next = div_q;
                    if (j_reg == n_reg)
                    begin
                        result_next.poly_value        = pn_reg;
                        result_next.first_derivative  = dn_reg;
                        result_next.second_derivative = div_q;
                        result_next.saturated         = clip_reg;
                        done_next                     = 1'b1;
                        state_next                    = lvd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + JW'(1);
                        state_next = lvd_pkg::ST_MUL_C;
                    end
                end
            end
            default:
            begin
                state_next = lvd_pkg::ST_IDLE;
            end
        endcase

        mul_ctl.start = mul_op && !launched_reg;
        div_start     = div_op && !launched_reg;
        if (mul_ctl.start || div_start)
            launched_next = 1'b1;
        if (mul_done || div_done)
            launched_next = 1'b0;
        if (mul_done)
            clip_next = clip_next | mul_clip;
    end

    lvd_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .product(mul_res),
        .clip   (mul_clip)
    );

    lvd_div #(
        .JW(JW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(t_reg),
        .divisor (j_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lvd_pkg::ST_IDLE;
            launched_reg <= 1'b0;
            done_reg     <= 1'b0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            done_reg     <= done_next;
            clip_reg     <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        n_reg      <= n_next;
        j_reg      <= j_next;
        c_reg      <= c_next;
        t_reg      <= t_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        pn_reg     <= pn_next;
        dn_reg     <= dn_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != lvd_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/lvd_checker.sv =====
module lvd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a transfer always starts work
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // results appear only once the item is finished
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while still busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without an item in work");

    // work never ends without delivering its result
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result");

endmodule

bind legendre_value_and_derivatives_core lvd_checker u_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (done)
);
